// ===== hdl/ofb_pkg.sv =====
// ofb_pkg: shared constants for the oled page frame buffer
// request codes, panel command bytes and default geometry
// no dependencies
`timescale 1ns / 1ps

package ofb_pkg;

    // default geometry: pages of 8 rows, column bytes per page
    localparam int PAGES_DEF      = 4;
    localparam int PAGE_WIDTH_DEF = 128;

    // request codes
    localparam logic [1:0] REQ_SET   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_TICK  = 2'd3;

    // panel page header
    localparam int         CMD_BYTES     = 4;
    localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

    // byte positions of the page header
    localparam logic [1:0] POS_PAGE_ADDR = 2'd0;
    localparam logic [1:0] POS_PAGE_NUM  = 2'd1;
    localparam logic [1:0] POS_COL_LOW   = 2'd2;
    localparam logic [1:0] POS_COL_HIGH  = 2'd3;

endpackage

// ===== hdl/ofb_store.sv =====
// ofb_store: column-organised pixel memory, one word holds all rows of a column
// registered read, write-through on same-address write, per-column valid bits
// no package dependencies
`timescale 1ns / 1ps

module ofb_store #(
    parameter int DEPTH  = 128,
    parameter int WORD_W = 32,
    parameter int ADDR_W = 7
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  col_valid_reg;
    logic [WORD_W-1:0] mem_q_reg;
    logic [WORD_W-1:0] fwd_data_reg;
    logic              fwd_hit_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // a column never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_valid_reg <= '0;
            fwd_hit_reg   <= 1'b0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                col_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
                rd_valid_reg <= col_valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = fwd_hit_reg  ? fwd_data_reg :
                     rd_valid_reg ? mem_q_reg    : '0;

endmodule

// ===== hdl/oled_page_framebuffer.sv =====
// oled_page_framebuffer: monochrome page frame buffer with panel refresh stream
// top level; uses ofb_pkg and ofb_store
// usage:
//   request channel (req_valid/req_ready) carries req_type, row and column:
//   set, clear or read one pixel, or one refresh tick that emits the next
//   byte of the panel stream (per page: 0x22, page number, 0x00, 0x10 as
//   commands, then PAGE_WIDTH data bytes; wraps after the last page)
//   result channel (rsp_valid/rsp_ready) returns exactly one result per
//   request, in order
// pipeline: a request passes through the memory read stage, then the
//   result register, before its result is presented
// throughput: one request per cycle while results are taken; the pixel memory has one read and one
//   write port, and a set or clear does its read-modify-write across the
//   two stages with write-through to a following access of the same column
// reset: stream position returns to page 0, header byte 0; every column of
//   the store reads as zero through per-column valid bits, no clearing pass
// stall: when rsp_ready is low the result register holds; a request can
//   still enter an empty read stage, and req_ready is low while the read
//   stage holds a request, until the result moves on
`timescale 1ns / 1ps

module oled_page_framebuffer #(
    parameter int PAGES      = ofb_pkg::PAGES_DEF,
    parameter int PAGE_WIDTH = ofb_pkg::PAGE_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  logic [1:0] req_type,
    input  logic [7:0] row,
    input  logic [7:0] column,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output logic       pixel_bit,
    output logic       in_range,
    output logic       stream_valid,
    output logic [7:0] stream_byte,
    output logic       data_mode,
    output logic       frame_end
);

    import ofb_pkg::*;

    // geometry
    localparam int ROWS    = PAGES * 8;
    localparam int ROW_W   = $clog2(ROWS);
    localparam int COL_W   = $clog2(PAGE_WIDTH);
    localparam int PG_W    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int OFF_MAX = PAGE_WIDTH + CMD_BYTES - 1;
    localparam int OFF_W   = $clog2(OFF_MAX + 1);

    // handshake
    logic req_xfer;
    logic s1_adv;

    // refresh position
    logic [PG_W-1:0]  page_reg;
    logic [OFF_W-1:0] offset_reg;

    // read stage
    logic             s1_valid_reg;
    logic [1:0]       s1_req_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_inside_reg;
    logic             s1_is_cmd_reg;
    logic [7:0]       s1_cmd_byte_reg;
    logic [PG_W-1:0]  s1_page_reg;
    logic             s1_fend_reg;

    // result register
    logic       rsp_valid_reg;
    logic       pixel_bit_reg;
    logic       in_range_reg;
    logic       stream_valid_reg;
    logic [7:0] stream_byte_reg;
    logic       data_mode_reg;
    logic       frame_end_reg;

    // request decode
    logic             is_tick;
    logic             in_frame;
    logic             off_is_cmd;
    logic [7:0]       cmd_byte;
    logic [COL_W-1:0] tick_col;
    logic             frame_last;

    // memory
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;
    logic             wr_en;
    logic [ROWS-1:0]  wr_data;
    logic [ROWS-1:0]  word;

    // stage 1 results
    logic             s1_bit;
    logic [7:0]       s1_data_byte;
    logic [ROWS-1:0]  row_mask;

    assign req_ready = !s1_valid_reg || s1_adv;
    assign req_xfer  = req_valid && req_ready;
    assign s1_adv    = s1_valid_reg && (!rsp_valid_reg || rsp_ready);

    // ---------------- request decode ----------------
    assign is_tick    = (req_type == REQ_TICK);
    assign in_frame   = ({1'b0, row} < 9'(ROWS)) && ({1'b0, column} < 9'(PAGE_WIDTH));
    assign off_is_cmd = (offset_reg < OFF_W'(CMD_BYTES));
    assign tick_col   = COL_W'(offset_reg - OFF_W'(CMD_BYTES));
    assign frame_last = (offset_reg == OFF_W'(OFF_MAX)) && (page_reg == PG_W'(PAGES - 1));

    // page header bytes
    always_comb
    begin
        case (offset_reg[1:0])
            POS_PAGE_ADDR: cmd_byte = CMD_PAGE_ADDR;
            POS_PAGE_NUM:  cmd_byte = 8'(page_reg);
            POS_COL_LOW:   cmd_byte = CMD_COL_LOW;
            POS_COL_HIGH:  cmd_byte = CMD_COL_HIGH;
            default:       cmd_byte = CMD_PAGE_ADDR;
        endcase
    end

    // memory is only read when the word is actually needed
    assign rd_en   = req_xfer && (is_tick ? !off_is_cmd : in_frame);
    assign rd_addr = is_tick ? tick_col : column[COL_W-1:0];

    // ---------------- refresh position ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg   <= '0;
            offset_reg <= '0;
        end
        else if (req_xfer && is_tick)
        begin
            if (offset_reg == OFF_W'(OFF_MAX))
            begin
                offset_reg <= '0;
                page_reg   <= (page_reg == PG_W'(PAGES - 1)) ? '0 : page_reg + 1'b1;
            end
            else
            begin
                offset_reg <= offset_reg + 1'b1;
            end
        end
    end

    // ---------------- read stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            s1_req_reg      <= req_type;
            s1_row_reg      <= row[ROW_W-1:0];
            s1_col_reg      <= column[COL_W-1:0];
            s1_inside_reg   <= in_frame;
            s1_is_cmd_reg   <= off_is_cmd;
            s1_cmd_byte_reg <= cmd_byte;
            s1_page_reg     <= page_reg;
            s1_fend_reg     <= frame_last;
        end
    end

    ofb_store #(
        .DEPTH  (PAGE_WIDTH),
        .WORD_W (ROWS),
        .ADDR_W (COL_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (s1_col_reg),
        .wr_data (wr_data),
        .rd_data (word)
    );

    // read-modify-write of the column word
    assign row_mask     = ROWS'(1) << s1_row_reg;
    assign s1_bit       = word[s1_row_reg];
    assign s1_data_byte = word[{s1_page_reg, 3'b000} +: 8];
    assign wr_en        = s1_adv && s1_inside_reg
                          && ((s1_req_reg == REQ_SET) || (s1_req_reg == REQ_CLEAR));
    assign wr_data      = (s1_req_reg == REQ_SET) ? (word | row_mask) : (word & ~row_mask);

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (!rsp_valid_reg || rsp_ready)
        begin
            rsp_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            if (s1_req_reg == REQ_TICK)
            begin
                pixel_bit_reg    <= 1'b0;
                in_range_reg     <= 1'b0;
                stream_valid_reg <= 1'b1;
                stream_byte_reg  <= s1_is_cmd_reg ? s1_cmd_byte_reg : s1_data_byte;
                data_mode_reg    <= !s1_is_cmd_reg;
                frame_end_reg    <= s1_fend_reg;
            end
            else
            begin
                pixel_bit_reg    <= (s1_req_reg == REQ_READ) && s1_inside_reg && s1_bit;
                in_range_reg     <= s1_inside_reg;
                stream_valid_reg <= 1'b0;
                stream_byte_reg  <= 8'h00;
                data_mode_reg    <= 1'b0;
                frame_end_reg    <= 1'b0;
            end
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign pixel_bit    = pixel_bit_reg;
    assign in_range     = in_range_reg;
    assign stream_valid = stream_valid_reg;
    assign stream_byte  = stream_byte_reg;
    assign data_mode    = data_mode_reg;
    assign frame_end    = frame_end_reg;

endmodule

// ===== sim/ofb_frame_checker.sv =====
// ofb_frame_checker: watches both channels of the page frame buffer, predicts each result
// from a private copy of the pixel store and stream position, and compares in order
// depends on ofb_pkg
`timescale 1ns / 1ps

module ofb_frame_checker
    import ofb_pkg::*;
#(
    parameter int PAGES      = PAGES_DEF,
    parameter int PAGE_WIDTH = PAGE_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_ready,
    input  logic [1:0] req_type,
    input  logic [7:0] row,
    input  logic [7:0] column,
    input  logic       rsp_valid,
    input  logic       rsp_ready,
    input  logic       pixel_bit,
    input  logic       in_range,
    input  logic       stream_valid,
    input  logic [7:0] stream_byte,
    input  logic       data_mode,
    input  logic       frame_end,
    output int         mismatch_count,
    output int         pending,
    output int         results_checked,
    output int         frames_streamed
);

    typedef struct packed {
        logic       pixel_bit;
        logic       in_range;
        logic       stream_valid;
        logic [7:0] stream_byte;
        logic       data_mode;
        logic       frame_end;
    } fb_result_t;

    localparam int MAX_REPORTS = 10;

    logic [7:0] frame_bytes [PAGES*PAGE_WIDTH];
    int         scan_page;
    int         scan_pos;
    fb_result_t results_due [$];
    fb_result_t want;
    fb_result_t got;
    int         errors;
    int         due_count;
    int         checked;
    int         frames;

    assign mismatch_count  = errors;
    assign pending         = due_count;
    assign results_checked = checked;
    assign frames_streamed = frames;

    // next panel byte, then step through header, data and page wrap
    function automatic fb_result_t next_stream_byte();
        fb_result_t res;
        int         col;
        res = '0;
        res.stream_valid = 1'b1;
        if (scan_pos < CMD_BYTES) begin
            case (scan_pos[1:0])
                POS_PAGE_ADDR: res.stream_byte = CMD_PAGE_ADDR;
                POS_PAGE_NUM:  res.stream_byte = scan_page[7:0];
                POS_COL_LOW:   res.stream_byte = CMD_COL_LOW;
                default:       res.stream_byte = CMD_COL_HIGH;
            endcase
        end
        else
        begin
            col = scan_pos - CMD_BYTES;
            res.stream_byte = frame_bytes[scan_page*PAGE_WIDTH + col];
            res.data_mode   = 1'b1;
            res.frame_end   = (col == PAGE_WIDTH - 1) && (scan_page == PAGES - 1);
        end
        if (scan_pos + 1 >= CMD_BYTES + PAGE_WIDTH) begin
            scan_pos  = 0;
            scan_page = (scan_page + 1 >= PAGES) ? 0 : scan_page + 1;
        end
        else
        begin
            scan_pos = scan_pos + 1;
        end
        return res;
    endfunction

    function automatic fb_result_t apply_request(input logic [1:0] kind,
                                                 input logic [7:0] r,
                                                 input logic [7:0] c);
        fb_result_t res;
        int         idx;
        logic [7:0] mask;
        res = '0;
        if (kind == REQ_TICK)
            return next_stream_byte();
        if (int'(r) >= PAGES*8 || int'(c) >= PAGE_WIDTH)
            return res;
        res.in_range = 1'b1;
        idx  = int'(r >> 3) * PAGE_WIDTH + int'(c);
        mask = 8'd1 << r[2:0];
        case (kind)
            REQ_SET:   frame_bytes[idx] = frame_bytes[idx] | mask;
            REQ_CLEAR: frame_bytes[idx] = frame_bytes[idx] & ~mask;
            default:   res.pixel_bit = (frame_bytes[idx] & mask) != 8'd0;
        endcase
        return res;
    endfunction

    task automatic check_field(input string field, input int actual, input int expected);
        if (actual != expected) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("mismatch in result %0d, %s: expected 0x%0h, got 0x%0h",
                         checked, field, expected, actual);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < PAGES*PAGE_WIDTH; i++)
                frame_bytes[i] = 8'd0;
            scan_page = 0;
            scan_pos  = 0;
            results_due.delete();
            due_count = 0;
            errors    = 0;
            checked   = 0;
            frames    = 0;
        end
        else
        begin
            // an older result leaves before a newer request is predicted
            if (rsp_valid && rsp_ready) begin
                got = {pixel_bit, in_range, stream_valid, stream_byte, data_mode, frame_end};
                if (results_due.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("result %0d arrived with nothing outstanding", checked);
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("pixel_bit", got.pixel_bit, want.pixel_bit);
                    check_field("in_range", got.in_range, want.in_range);
                    check_field("stream_valid", got.stream_valid, want.stream_valid);
                    check_field("stream_byte", got.stream_byte, want.stream_byte);
                    check_field("data_mode", got.data_mode, want.data_mode);
                    check_field("frame_end", got.frame_end, want.frame_end);
                end
                checked++;
                if (frame_end)
                    frames++;
            end
            if (req_valid && req_ready)
                results_due.push_back(apply_request(req_type, row, column));
            due_count = results_due.size();
        end
    end

endmodule

// ===== sim/oled_page_framebuffer_tb.sv =====
// oled_page_framebuffer_tb: stimulus and verdict for the page frame buffer
// directed pixel and refresh cases, then a random mix dominated by refresh ticks
// depends on ofb_pkg, ofb_frame_checker and the oled_page_framebuffer rtl
`timescale 1ns / 1ps

module oled_page_framebuffer_tb;
    import ofb_pkg::*;

    localparam int ROWS        = PAGES_DEF * 8;
    localparam int RANDOM_REQS = 800;
    // one full frame of ticks is PAGES * (header + data) bytes
    localparam int MIN_TICKS   = 600;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 10;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    logic [1:0] req_type  = REQ_SET;
    logic [7:0] row       = 8'd0;
    logic [7:0] column    = 8'd0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    logic       pixel_bit;
    logic       in_range;
    logic       stream_valid;
    logic [7:0] stream_byte;
    logic       data_mode;
    logic       frame_end;

    int mismatch_count;
    int pending;
    int results_checked;
    int frames_streamed;

    // set while both sides run back to back with no idling
    logic busy_window = 1'b0;

    // per-kind transfer counts for the closing summary, and the watchdog's idle count
    int sets_sent;
    int clears_sent;
    int reads_sent;
    int ticks_sent;
    int outside_sent;
    int stall_cycles;

    always #5 clk = ~clk;

    oled_page_framebuffer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req_type     (req_type),
        .row          (row),
        .column       (column),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .pixel_bit    (pixel_bit),
        .in_range     (in_range),
        .stream_valid (stream_valid),
        .stream_byte  (stream_byte),
        .data_mode    (data_mode),
        .frame_end    (frame_end)
    );

    ofb_frame_checker frame_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .req_type        (req_type),
        .row             (row),
        .column          (column),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .pixel_bit       (pixel_bit),
        .in_range        (in_range),
        .stream_valid    (stream_valid),
        .stream_byte     (stream_byte),
        .data_mode       (data_mode),
        .frame_end       (frame_end),
        .mismatch_count  (mismatch_count),
        .pending         (pending),
        .results_checked (results_checked),
        .frames_streamed (frames_streamed)
    );

    // result side back-pressure: low about 7 percent of the time, outside the busy window
    always @(posedge clk)
        rsp_ready <= busy_window || ($urandom_range(0, 99) >= 7);

    // watchdog: any transfer on either channel restarts the count
    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("no transfer for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, pending);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // one request transfer; called right after a rising edge, drives with
    // nonblocking assignments and returns at the edge that took the transfer
    task automatic send_req(input logic [1:0] kind, input logic [7:0] r, input logic [7:0] c);
        logic taken;
        while (!busy_window && $urandom_range(0, 99) < 7) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= kind;
        row       <= r;
        column    <= c;
        // ready is stable by the falling edge, so sample it there
        do begin
            @(negedge clk);
            taken = req_ready;
            @(posedge clk);
        end while (!taken);
        case (kind)
            REQ_SET:   sets_sent++;
            REQ_CLEAR: clears_sent++;
            REQ_READ:  reads_sent++;
            default:   ticks_sent++;
        endcase
        if (kind != REQ_TICK && (int'(r) >= ROWS || int'(c) >= PAGE_WIDTH_DEF))
            outside_sent++;
    endtask

    initial begin
        int         n;
        int         pick;
        logic [1:0] kind;
        logic [7:0] r;
        logic [7:0] c;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners and page boundary bits, read back after the writes; each clear is read back straight after
        send_req(REQ_SET, 8'd0, 8'd0);
        send_req(REQ_SET, 8'd31, 8'd127);
        send_req(REQ_SET, 8'd7, 8'd64);
        send_req(REQ_SET, 8'd8, 8'd64);
        send_req(REQ_READ, 8'd0, 8'd0);
        send_req(REQ_READ, 8'd31, 8'd127);
        send_req(REQ_READ, 8'd1, 8'd0);
        send_req(REQ_READ, 8'd8, 8'd64);
        send_req(REQ_CLEAR, 8'd0, 8'd0);
        send_req(REQ_READ, 8'd0, 8'd0);
        send_req(REQ_CLEAR, 8'd7, 8'd64);
        send_req(REQ_READ, 8'd7, 8'd64);
        // writes outside the frame must leave the store alone
        send_req(REQ_SET, 8'd32, 8'd0);
        send_req(REQ_SET, 8'd0, 8'd128);
        send_req(REQ_SET, 8'd255, 8'd255);
        send_req(REQ_CLEAR, 8'd31, 8'd128);
        send_req(REQ_SET, 8'hAA, 8'h55);
        // reads outside the frame give zero and no in_range; a last read inside finds the corner bit still set
        send_req(REQ_READ, 8'd32, 8'd127);
        send_req(REQ_READ, 8'd255, 8'd255);
        send_req(REQ_READ, 8'd31, 8'd127);
        // ticks ignore coordinates; run through the header into page 0 data
        send_req(REQ_TICK, 8'd255, 8'd255);
        send_req(REQ_TICK, 8'd0, 8'd0);
        for (int i = 0; i < 3; i++)
            send_req(REQ_TICK, 8'h55, 8'hAA);

        // random mix: mostly ticks so the stream wraps past a full frame,
        // pixel traffic concentrated on a small spot so reads and refresh
        // bytes see nonzero data
        n = 0;
        while (n < RANDOM_REQS || ticks_sent < MIN_TICKS) begin
            busy_window = (n >= 300 && n < 450);
            r = 8'($urandom_range(0, 255));
            c = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 70) begin
                kind = REQ_TICK;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                kind = (pick < 40) ? REQ_SET : (pick < 65) ? REQ_CLEAR : REQ_READ;
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    // hot spot straddling the page 0 / page 1 boundary at both frame edges
                    r = 8'($urandom_range(4, 11));
                    c = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 1))
                                                    : 8'($urandom_range(126, 127));
                end
                else if (pick < 80) begin
                    r = 8'($urandom_range(0, ROWS - 1));
                    c = 8'($urandom_range(0, PAGE_WIDTH_DEF - 1));
                end
            end
            send_req(kind, r, c);
            n++;
        end
        busy_window = 1'b0;
        req_valid <= 1'b0;

        // drain: the watchdog bounds this wait
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("sent %0d sets, %0d clears, %0d reads (%0d outside the frame), %0d ticks",
                 sets_sent, clears_sent, reads_sent, outside_sent, ticks_sent);
        $display("compared %0d results, saw %0d complete frame(s), %0d mismatch(es)",
                 results_checked, frames_streamed, mismatch_count);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
